### design/sdtc_pkg.sv
// space-delimited token classifier: shared types, character constants and
// byte-class helpers; used by every module of the block
package sdtc_pkg;

  // queue between the classifier and the result sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // lexer modes
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_IDENT  = 4'd1,
    MODE_NUMBER = 4'd2,
    MODE_OPER   = 4'd3,
    MODE_SLASH  = 4'd4,
    MODE_BLOCK  = 4'd5,
    MODE_BSTAR  = 4'd6,
    MODE_SKIP   = 4'd7,
    MODE_LINE   = 4'd8
  } mode_t;

  // reported token kinds
  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_OPER    = 3'd2,
    KIND_COMMENT = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  // results caused by one character: one or two kinds
  typedef struct packed {
    logic  two;
    kind_t first;
    kind_t second;
  } work_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_EQUAL ||
           c == CH_STAR || c == CH_AMP || c == CH_PIPE;
  endfunction

endpackage

### design/sdtc_in_if.sv
// character channel: valid/ready handshake with one character per transfer
// standalone, no dependencies
interface sdtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_final;

  modport source (output valid, output char_byte, output is_final, input ready);
  modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

### design/sdtc_out_if.sv
// token channel: valid/ready handshake with one token result per transfer
// standalone, no dependencies
interface sdtc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic       last_result;

  modport source (output valid, output token_kind, output last_result, input ready);
  modport sink   (input valid, input token_kind, input last_result, output ready);
endinterface

### design/space_delimited_token_classifier_unit.sv
// space-delimited token classifier, top level
// ties classifier front end, work queue and result sequencer together
// depends on sdtc_pkg, sdtc_in_if, sdtc_out_if and the sdtc_* modules
//
// char_in carries one text character per transfer with a final-character
// flag; tok_out carries token results (kind and a last-result flag).
// A character that closes a token, fails a token or ends the text yields
// one or two results; other characters yield none.
// Throughput: one character per cycle while results are taken; the result
// sequencer sends one result per cycle while taken, so characters that yield
// two results are absorbed by the four-entry work queue, then throttle char_in.
// The results of a character pass through the queue write and then the
// output register before tok_out.valid rises, and they transfer when
// nothing is stalled.
// When tok_out stalls, the output register holds, the queue fills, and
// char_in.ready drops once the queue is full.
// Synchronous reset clears the lexer to idle between tokens and empties
// the queue and output register; no clearing pass is needed.
module space_delimited_token_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  sdtc_in_if.sink     char_in,
  sdtc_out_if.source  tok_out
);

  logic            push;
  sdtc_pkg::work_t push_data;
  logic            q_full;
  logic            q_valid;
  sdtc_pkg::work_t q_head;
  logic            q_pop;

  sdtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  sdtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  sdtc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .tok_out (tok_out)
  );

endmodule

### design/sdtc_front.sv
// classifier front end: lexer state machine, one character per transfer
// depends on sdtc_pkg and sdtc_in_if
module sdtc_front (
  input  logic              clk,
  input  logic              rst,
  sdtc_in_if.sink           char_in,
  input  logic              q_full,
  output logic              push,
  output sdtc_pkg::work_t   push_data
);

  sdtc_pkg::mode_t mode;
  sdtc_pkg::mode_t mode_next;
  sdtc_pkg::mode_t m_step;
  sdtc_pkg::kind_t step_kind;
  logic            step_emit;
  logic            open_tok;
  logic            has_result;
  logic            accept;
  logic [7:0]      c;

  assign c            = char_in.char_byte;
  assign char_in.ready = !q_full;
  assign accept       = char_in.valid && char_in.ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sdtc_pkg::MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  // transition on the character class, then end-of-text handling
  always_comb begin
    m_step    = mode;
    step_emit = 1'b0;
    step_kind = sdtc_pkg::KIND_ERROR;
    case (mode)
      sdtc_pkg::MODE_IDLE: begin
        if (c == sdtc_pkg::CH_SPACE) m_step = sdtc_pkg::MODE_IDLE;
        else if (sdtc_pkg::is_letter(c)) m_step = sdtc_pkg::MODE_IDENT;
        else if (sdtc_pkg::is_digit(c)) m_step = sdtc_pkg::MODE_NUMBER;
        else if (sdtc_pkg::is_op(c)) m_step = sdtc_pkg::MODE_OPER;
        else if (c == sdtc_pkg::CH_SLASH) m_step = sdtc_pkg::MODE_SLASH;
        else begin
          step_emit = 1'b1;
          m_step    = sdtc_pkg::MODE_SKIP;
        end
      end
      sdtc_pkg::MODE_IDENT: begin
        if (!(sdtc_pkg::is_letter(c) || sdtc_pkg::is_digit(c))) begin
          step_emit = 1'b1;
          if (c == sdtc_pkg::CH_SPACE) begin
            step_kind = sdtc_pkg::KIND_IDENT;
            m_step    = sdtc_pkg::MODE_IDLE;
          end else begin
            m_step = sdtc_pkg::MODE_SKIP;
          end
        end
      end
      sdtc_pkg::MODE_NUMBER: begin
        if (!(sdtc_pkg::is_digit(c) || c == sdtc_pkg::CH_DOT)) begin
          step_emit = 1'b1;
          if (c == sdtc_pkg::CH_SPACE) begin
            step_kind = sdtc_pkg::KIND_NUMBER;
            m_step    = sdtc_pkg::MODE_IDLE;
          end else begin
            m_step = sdtc_pkg::MODE_SKIP;
          end
        end
      end
      sdtc_pkg::MODE_OPER: begin
        if (!sdtc_pkg::is_op(c)) begin
          step_emit = 1'b1;
          if (c == sdtc_pkg::CH_SPACE) begin
            step_kind = sdtc_pkg::KIND_OPER;
            m_step    = sdtc_pkg::MODE_IDLE;
          end else begin
            m_step = sdtc_pkg::MODE_SKIP;
          end
        end
      end
      sdtc_pkg::MODE_SLASH: begin
        step_emit = 1'b1;
        if (c == sdtc_pkg::CH_SLASH) begin
          step_kind = sdtc_pkg::KIND_COMMENT;
          m_step    = sdtc_pkg::MODE_LINE;
        end else if (c == sdtc_pkg::CH_STAR) begin
          step_emit = 1'b0;
          m_step    = sdtc_pkg::MODE_BLOCK;
        end else if (c == sdtc_pkg::CH_SPACE) begin
          step_kind = sdtc_pkg::KIND_OPER;
          m_step    = sdtc_pkg::MODE_IDLE;
        end else begin
          m_step = sdtc_pkg::MODE_SKIP;
        end
      end
      sdtc_pkg::MODE_BLOCK: begin
        m_step = (c == sdtc_pkg::CH_STAR) ? sdtc_pkg::MODE_BSTAR : sdtc_pkg::MODE_BLOCK;
      end
      sdtc_pkg::MODE_BSTAR: begin
        step_emit = 1'b1;
        if (c == sdtc_pkg::CH_SLASH) begin
          step_kind = sdtc_pkg::KIND_COMMENT;
          m_step    = sdtc_pkg::MODE_IDLE;
        end else begin
          m_step = (c == sdtc_pkg::CH_SPACE) ? sdtc_pkg::MODE_IDLE : sdtc_pkg::MODE_SKIP;
        end
      end
      sdtc_pkg::MODE_SKIP: begin
        m_step = (c == sdtc_pkg::CH_SPACE) ? sdtc_pkg::MODE_IDLE : sdtc_pkg::MODE_SKIP;
      end
      sdtc_pkg::MODE_LINE: begin
        m_step = sdtc_pkg::MODE_LINE;
      end
      default: begin
        m_step = sdtc_pkg::MODE_IDLE;
      end
    endcase

    // token or block comment still open when the text ends
    open_tok = m_step == sdtc_pkg::MODE_IDENT || m_step == sdtc_pkg::MODE_NUMBER ||
               m_step == sdtc_pkg::MODE_OPER  || m_step == sdtc_pkg::MODE_SLASH  ||
               m_step == sdtc_pkg::MODE_BLOCK || m_step == sdtc_pkg::MODE_BSTAR;

    // pack the results of this character
    push_data.two    = 1'b0;
    push_data.first  = step_kind;
    push_data.second = sdtc_pkg::KIND_END;
    if (step_emit) begin
      push_data.two = char_in.is_final;
    end else if (char_in.is_final && open_tok) begin
      push_data.first = sdtc_pkg::KIND_ERROR;
      push_data.two   = 1'b1;
    end else if (char_in.is_final) begin
      push_data.first = sdtc_pkg::KIND_END;
    end

    has_result = step_emit || char_in.is_final;
    mode_next  = char_in.is_final ? sdtc_pkg::MODE_IDLE : m_step;
  end

  assign push = accept && has_result;

endmodule

### design/sdtc_queue.sv
// work queue between the classifier and the result sequencer
// depends on sdtc_pkg
module sdtc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sdtc_pkg::work_t push_data,
  output logic            full,
  output logic            valid,
  output sdtc_pkg::work_t head,
  input  logic            pop
);

  sdtc_pkg::work_t                   mem [sdtc_pkg::QUEUE_DEPTH];
  logic [sdtc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sdtc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sdtc_pkg::QCNT_W-1:0]       count;

  assign full  = count == sdtc_pkg::QCNT_W'(sdtc_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sdtc_pkg::QCNT_W'(sdtc_pkg::QUEUE_DEPTH))
    else $error("queue fill level out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[sdtc_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with fill level");
`endif

endmodule

### design/sdtc_back.sv
// result sequencer: sends the one or two results of each queue entry
// through a registered output stage; depends on sdtc_pkg and sdtc_out_if
module sdtc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sdtc_pkg::work_t q_head,
  output logic            q_pop,
  sdtc_out_if.source      tok_out
);

  logic            out_valid;
  sdtc_pkg::kind_t out_kind;
  logic            out_last;
  logic            phase;
  logic            load;

  assign load  = (!out_valid || tok_out.ready) && q_valid;
  assign q_pop = load && (phase || !q_head.two);

  // output register and second-result phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !phase && q_head.two;
      end else if (tok_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= phase ? q_head.second : q_head.first;
      out_last <= phase || !q_head.two;
    end
  end

  assign tok_out.valid       = out_valid;
  assign tok_out.token_kind  = out_kind;
  assign tok_out.last_result = out_last;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench for the space-delimited token classifier: a directed text table, then
// random texts in three idling phases; each token checked by a lexer predictor or typed row
// depends on sdtc_pkg, sdtc_in_if, sdtc_out_if and space_delimited_token_classifier_unit
module tb;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 600;
  localparam int N_ROWS      = 29;

  typedef struct packed {
    sdtc_pkg::kind_t kind;
    logic            last;
  } token_rec_t;

  // one directed character; typed rows carry their expected tokens
  typedef struct {
    logic [7:0]      ch;
    logic            fin;
    bit              typed;
    int unsigned     n;
    sdtc_pkg::kind_t k0;
    sdtc_pkg::kind_t k1;
  } text_row_t;

  logic clk = 1'b0;
  logic rst;

  sdtc_in_if  char_ch();
  sdtc_out_if tok_ch();

  token_rec_t      pending_tokens[$];
  logic [7:0]      text_buf[$];
  sdtc_pkg::mode_t tracked_mode   = sdtc_pkg::MODE_IDLE;
  int unsigned     mismatch_count = 0;
  int unsigned     live_items     = 0;
  int unsigned     src_idle_pct   = 11;
  int unsigned     snk_idle_pct   = 53;
  int unsigned     holds_asked    = 0;
  int unsigned     holds_done     = 0;
  int unsigned     quiet_cycles   = 0;
  text_row_t       text_rows[N_ROWS];

  space_delimited_token_classifier_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_ch),
    .tok_out (tok_ch)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'(8'h61 + $urandom_range(25));
    return 8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(5))
      0: return sdtc_pkg::CH_PLUS;
      1: return sdtc_pkg::CH_MINUS;
      2: return sdtc_pkg::CH_EQUAL;
      3: return sdtc_pkg::CH_STAR;
      4: return sdtc_pkg::CH_AMP;
      default: return sdtc_pkg::CH_PIPE;
    endcase
  endfunction

  task automatic await_drain();
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // one character transfer, then the predicted tokens it causes
  task automatic send_char(input logic [7:0] ch, input logic fin, input bit typed = 1'b0,
                           input int unsigned tn = 0,
                           input sdtc_pkg::kind_t tk0 = sdtc_pkg::KIND_END,
                           input sdtc_pkg::kind_t tk1 = sdtc_pkg::KIND_END);
    sdtc_pkg::kind_t got[$];
    sdtc_pkg::mode_t nxt;
    sdtc_pkg::kind_t close_kind;
    logic            alpha, num, opc, space_c, closing;
    // random gap before the transfer
    while ($urandom_range(99) < src_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_byte <= ch;
    char_ch.is_final  <= fin;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);

    // byte classes
    alpha      = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    num        = ch inside {[8'h30:8'h39]};
    opc        = ch inside {sdtc_pkg::CH_PLUS, sdtc_pkg::CH_MINUS, sdtc_pkg::CH_EQUAL,
                            sdtc_pkg::CH_STAR, sdtc_pkg::CH_AMP, sdtc_pkg::CH_PIPE};
    space_c    = (ch == sdtc_pkg::CH_SPACE);
    closing    = 1'b0;
    close_kind = sdtc_pkg::KIND_IDENT;
    nxt        = tracked_mode;
    live_items++;

    // lexer step
    case (tracked_mode)
      sdtc_pkg::MODE_IDLE: begin
        if (space_c) nxt = sdtc_pkg::MODE_IDLE;
        else if (alpha) nxt = sdtc_pkg::MODE_IDENT;
        else if (num) nxt = sdtc_pkg::MODE_NUMBER;
        else if (opc) nxt = sdtc_pkg::MODE_OPER;
        else if (ch == sdtc_pkg::CH_SLASH) nxt = sdtc_pkg::MODE_SLASH;
        else begin
          got.push_back(sdtc_pkg::KIND_ERROR);
          nxt = sdtc_pkg::MODE_SKIP;
        end
      end
      sdtc_pkg::MODE_IDENT: begin
        if (!(alpha || num)) begin
          closing    = 1'b1;
          close_kind = sdtc_pkg::KIND_IDENT;
        end
      end
      sdtc_pkg::MODE_NUMBER: begin
        if (!(num || ch == sdtc_pkg::CH_DOT)) begin
          closing    = 1'b1;
          close_kind = sdtc_pkg::KIND_NUMBER;
        end
      end
      sdtc_pkg::MODE_OPER: begin
        if (!opc) begin
          closing    = 1'b1;
          close_kind = sdtc_pkg::KIND_OPER;
        end
      end
      sdtc_pkg::MODE_SLASH: begin
        if (ch == sdtc_pkg::CH_SLASH) begin
          got.push_back(sdtc_pkg::KIND_COMMENT);
          nxt = sdtc_pkg::MODE_LINE;
        end else if (ch == sdtc_pkg::CH_STAR) begin
          nxt = sdtc_pkg::MODE_BLOCK;
        end else begin
          closing    = 1'b1;
          close_kind = sdtc_pkg::KIND_OPER;
        end
      end
      sdtc_pkg::MODE_BLOCK:
        nxt = (ch == sdtc_pkg::CH_STAR) ? sdtc_pkg::MODE_BSTAR : sdtc_pkg::MODE_BLOCK;
      sdtc_pkg::MODE_BSTAR: begin
        if (ch == sdtc_pkg::CH_SLASH) begin
          got.push_back(sdtc_pkg::KIND_COMMENT);
          nxt = sdtc_pkg::MODE_IDLE;
        end else begin
          got.push_back(sdtc_pkg::KIND_ERROR);
          nxt = space_c ? sdtc_pkg::MODE_IDLE : sdtc_pkg::MODE_SKIP;
        end
      end
      sdtc_pkg::MODE_SKIP: if (space_c) nxt = sdtc_pkg::MODE_IDLE;
      sdtc_pkg::MODE_LINE: nxt = sdtc_pkg::MODE_LINE;
      default: nxt = sdtc_pkg::MODE_IDLE;
    endcase

    // a space closes the open token, anything else fails it
    if (closing) begin
      got.push_back(space_c ? close_kind : sdtc_pkg::KIND_ERROR);
      nxt = space_c ? sdtc_pkg::MODE_IDLE : sdtc_pkg::MODE_SKIP;
    end

    // last character of the text: flag anything left open, then the end marker
    if (fin) begin
      if (nxt inside {sdtc_pkg::MODE_IDENT, sdtc_pkg::MODE_NUMBER, sdtc_pkg::MODE_OPER,
                      sdtc_pkg::MODE_SLASH, sdtc_pkg::MODE_BLOCK, sdtc_pkg::MODE_BSTAR})
        got.push_back(sdtc_pkg::KIND_ERROR);
      got.push_back(sdtc_pkg::KIND_END);
      nxt = sdtc_pkg::MODE_IDLE;
    end
    tracked_mode = nxt;

    // typed rows replace the prediction with their own tokens
    if (typed) begin
      got.delete();
      if (tn > 0) got.push_back(tk0);
      if (tn > 1) got.push_back(tk1);
    end
    foreach (got[i]) pending_tokens.push_back('{kind: got[i], last: (i == got.size() - 1)});
  endtask

  // random text: mostly well-formed tokens, some broken ones and raw noise
  task automatic build_text();
    int unsigned n_tok, len, pick;
    logic [7:0]  b;
    text_buf.delete();
    n_tok = $urandom_range(6, 1);
    repeat (n_tok) begin
      pick = $urandom_range(99);
      len  = $urandom_range(5);
      if (pick < 24) begin
        text_buf.push_back(rand_letter());
        repeat (len) text_buf.push_back($urandom_range(1) ? rand_letter() : rand_digit());
      end else if (pick < 42) begin
        text_buf.push_back(rand_digit());
        repeat (len)
          text_buf.push_back(($urandom_range(3) == 0) ? sdtc_pkg::CH_DOT : rand_digit());
      end else if (pick < 58) begin
        repeat (len + 1) text_buf.push_back(rand_op());
      end else if (pick < 63) begin
        text_buf.push_back(sdtc_pkg::CH_SLASH);
      end else if (pick < 73) begin
        text_buf.push_back(sdtc_pkg::CH_SLASH);
        text_buf.push_back(sdtc_pkg::CH_STAR);
        repeat (len) begin
          b = 8'($urandom_range(255));
          text_buf.push_back((b == sdtc_pkg::CH_STAR) ? sdtc_pkg::CH_MINUS : b);
        end
        text_buf.push_back(sdtc_pkg::CH_STAR);
        // now and then a star that is not closed by a slash
        text_buf.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                    : sdtc_pkg::CH_SLASH);
      end else if (pick < 76) begin
        text_buf.push_back(sdtc_pkg::CH_SLASH);
        text_buf.push_back(sdtc_pkg::CH_SLASH);
        repeat (len) text_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 90) begin
        text_buf.push_back($urandom_range(1) ? rand_letter() : rand_digit());
        text_buf.push_back(8'($urandom_range(255)));
      end else begin
        repeat (len + 1) text_buf.push_back(8'($urandom_range(255)));
      end
      repeat ($urandom_range(2, 1)) text_buf.push_back(sdtc_pkg::CH_SPACE);
    end
    // drop one trailing space half the time, which can leave the last token open
    if ($urandom_range(1)) void'(text_buf.pop_back());
  endtask

  // token sink: random stalls, long hold-off on request
  initial begin
    tok_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        tok_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        tok_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // token check and watchdog
  always @(posedge clk) begin
    token_rec_t want;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d last %0d",
                 $time, tok_ch.token_kind, tok_ch.last_result);
        mismatch_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (tok_ch.token_kind !== want.kind) begin
          $display("%0t: token_kind: expected %0d, actual %0d",
                   $time, want.kind, tok_ch.token_kind);
          mismatch_count++;
        end
        if (tok_ch.last_result !== want.last) begin
          $display("%0t: last_result: expected %0d, actual %0d",
                   $time, want.last, tok_ch.last_result);
          mismatch_count++;
        end
      end
    end
    if (rst || (tok_ch.valid && tok_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned phase_end;
    rst               <= 1'b1;
    char_ch.valid     <= 1'b0;
    char_ch.char_byte <= '0;
    char_ch.is_final  <= 1'b0;
    text_rows = '{
      // stray byte right after reset
      '{8'h00, 1'b0, 1'b1, 1, sdtc_pkg::KIND_ERROR, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // identifier
      '{"a", 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{"9", 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // number with a dot
      '{"0", 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_DOT, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // operator run
      '{sdtc_pkg::CH_PLUS, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_PIPE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // lone slash
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // slash then letter
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{"x", 1'b0, 1'b1, 1, sdtc_pkg::KIND_ERROR, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // star in block not closed
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_STAR, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_STAR, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{"q", 1'b0, 1'b1, 1, sdtc_pkg::KIND_ERROR, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SPACE, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // empty block comment
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_STAR, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_STAR, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      // identifier open at end
      '{"Z", 1'b1, 1'b1, 2, sdtc_pkg::KIND_ERROR, sdtc_pkg::KIND_END},
      // line comment
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{sdtc_pkg::CH_SLASH, 1'b0, 1'b0, 0, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END},
      '{8'hFF, 1'b1, 1'b1, 1, sdtc_pkg::KIND_END, sdtc_pkg::KIND_END}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (text_rows[r])
      send_char(text_rows[r].ch, text_rows[r].fin, text_rows[r].typed, text_rows[r].n,
                text_rows[r].k0, text_rows[r].k1);
    char_ch.valid <= 1'b0;
    await_drain();

    // random texts: sender mostly busy, then sink mostly busy, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 53 : 0;
      snk_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 11 : 0;
      phase_end    = live_items + PHASE_ITEMS;
      while (live_items < phase_end) begin
        // halfway through the first phase the sink holds off while characters keep coming
        if (ph == 0 && holds_asked == 0 && live_items + PHASE_ITEMS / 2 >= phase_end)
          holds_asked++;
        build_text();
        foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
      end
      // sender pauses until every token of the phase has come back
      char_ch.valid <= 1'b0;
      await_drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
